FILE: rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

   localparam int OPERAND_WIDTH_DEF = 32;
   localparam int DATA_WIDTH        = 32;
   localparam int EXP_WIDTH         = 64;

   typedef struct packed {
      logic load;       // capture base and exponent, acc <= 1
      logic sqr_sel;    // multiply radix*radix, else acc*radix
      logic mul_en;     // register product, start reduction
      logic div_en;     // one remainder bit
      logic wr_en;      // write reduced value back
      logic shift_en;   // drop the exponent lsb
   } mexp_cmd_type;

   typedef struct packed {
      logic exp_zero;
      logic exp_lsb;
      logic exp_high_zero;
      logic div_last;
   } mexp_status_type;

endpackage

FILE: rtl/mexp_ctrl.sv
`timescale 1ns / 1ps

module mexp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  mexp_pkg::mexp_status_type status,
   output mexp_pkg::mexp_cmd_type    cmd,
   output logic                      busy,
   output logic                      done
);
   import mexp_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_SHIFT = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      sqr_ff, sqr_in;

   always_comb begin
      state_in = state_ff;
      sqr_in   = sqr_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = ST_DONE;
            end else if (status.exp_lsb) begin
               sqr_in   = 1'b0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_MUL: begin
            cmd.sqr_sel = sqr_ff;
            cmd.mul_en  = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.sqr_sel = sqr_ff;
            cmd.div_en  = 1'b1;
            if (status.div_last) begin
               cmd.wr_en = 1'b1;
               state_in  = sqr_ff ? ST_CHECK : ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (status.exp_high_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.shift_en = 1'b1;
               sqr_in       = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sqr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sqr_ff   <= sqr_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

endmodule

FILE: rtl/mexp_dp.sv
`timescale 1ns / 1ps

module mexp_dp #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mexp_pkg::mexp_cmd_type              cmd,
   output mexp_pkg::mexp_status_type           status,
   input  logic                                csr_write,
   input  logic [mexp_pkg::DATA_WIDTH-1:0]     csr_data,
   input  logic [mexp_pkg::DATA_WIDTH-1:0]     base,
   input  logic [mexp_pkg::EXP_WIDTH-1:0]      exponent,
   output logic [mexp_pkg::DATA_WIDTH-1:0]     power_result
);
   import mexp_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int CW = $clog2(PW);

   logic [W-1:0]         modulus_ff, modulus_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [W-1:0]         radix_ff, radix_in;
   logic [EXP_WIDTH-1:0] exp_ff, exp_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [W-1:0]         rem_ff, rem_in;
   logic [CW-1:0]        idx_ff, idx_in;

   logic [W-1:0]         mul_a;
   logic [W:0]           trial;
   logic [W:0]           trial_sub;
   logic [W-1:0]         rem_step;
   logic [W-1:0]         reduced;
   logic                 mod_zero;

   assign mod_zero  = (modulus_ff == '0);
   assign mul_a     = cmd.sqr_sel ? radix_ff : acc_ff;

   // restoring division, one dividend bit per cycle, msb first
   assign trial     = {rem_ff, prod_ff[idx_ff]};
   assign trial_sub = trial - {1'b0, modulus_ff};
   assign rem_step  = (trial >= {1'b0, modulus_ff}) ? trial_sub[W-1:0] : trial[W-1:0];
   assign reduced   = mod_zero ? prod_ff[W-1:0] : rem_step;

   always_comb begin
      modulus_in = csr_write ? csr_data[W-1:0] : modulus_ff;
      acc_in     = acc_ff;
      radix_in   = radix_ff;
      exp_in     = exp_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      if (cmd.load) begin
         acc_in   = W'(1);
         radix_in = base[W-1:0];
         exp_in   = exponent;
      end
      if (cmd.shift_en) begin
         exp_in = exp_ff >> 1;
      end
      if (cmd.mul_en) begin
         prod_in = PW'(mul_a) * PW'(radix_ff);
         rem_in  = '0;
         idx_in  = CW'(PW - 1);
      end
      if (cmd.div_en) begin
         rem_in = rem_step;
         idx_in = idx_ff - CW'(1);
      end
      if (cmd.wr_en) begin
         if (cmd.sqr_sel) begin
            radix_in = reduced;
         end else begin
            acc_in = reduced;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= W'(1);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      radix_ff <= radix_in;
      exp_ff   <= exp_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      idx_ff   <= idx_in;
   end

   assign status.exp_zero      = (exp_ff == '0);
   assign status.exp_lsb       = exp_ff[0];
   assign status.exp_high_zero = (exp_ff[EXP_WIDTH-1:1] == '0);
   assign status.div_last      = (idx_ff == '0);

   assign power_result = DATA_WIDTH'(acc_ff);

endmodule

FILE: rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// Each modular product is a multiply step followed by a bit-serial divider over
// the 2W-bit product, W = OPERAND_WIDTH.
// One request at a time: busy stays high through the result strobe, and the next
// request is accepted once busy falls; rsp cannot stall.
// Synchronous reset returns the controller to idle and the modulus to 1.
module modular_exponentiation #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mexp_pkg::DATA_WIDTH-1:0]     req_base,
   input  logic [mexp_pkg::EXP_WIDTH-1:0]      req_exponent,
   output logic                                rsp_strobe,
   output logic [mexp_pkg::DATA_WIDTH-1:0]     rsp_power_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mexp_pkg::DATA_WIDTH-1:0]     csr_modulus
);
   import mexp_pkg::*;

   mexp_cmd_type    cmd;
   mexp_status_type status;
   logic            csr_write;

   assign csr_ready = ~busy & ~start;
   assign csr_write = csr_valid & csr_ready;

   mexp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_strobe)
   );

   mexp_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_write    (csr_write),
      .csr_data     (csr_modulus),
      .base         (req_base),
      .exponent     (req_exponent),
      .power_result (rsp_power_result)
   );

endmodule
